// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the ellipse rasterizer RTL.
// Self-contained; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, ck, rn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rn, cond, msg)

`endif

`endif

// ===== hdl/ber_pkg.sv =====
// Shared types and constants for the ellipse rasterizer.
// No dependencies; used by ber_ctrl, ber_dp, ber_out and the top level.
package ber_pkg;

    // Width of the running error term
    localparam int ERR_BITS = 40;

    // Points emitted for every step and index of the final one
    localparam int          POINTS_PER_STEP = 4;
    localparam logic [1:0]  LAST_POINT      = 2'(POINTS_PER_STEP - 1);

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_MUL,
        ST_START_INIT,
        ST_STEP_EVAL,
        ST_STEP_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        MOVE_H,
        MOVE_V,
        MOVE_D
    } move_t;

    typedef struct packed {
        logic load_geom;
        logic start_mul;
        logic start_init;
        logic step_mul;
        logic step_eval;
        logic step_commit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic emit_free;
    } status_t;

endpackage

// ===== hdl/ber_ctrl.sv =====
// Sequencer for the ellipse rasterizer: accepts items and issues datapath commands.
// Depends on ber_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ber_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ber_pkg::op_t     op,
    output logic             in_ready,
    input  ber_pkg::status_t stat,
    output ber_pkg::cmd_t    cmd
);

    ber_pkg::state_t state_reg;
    ber_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ber_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ber_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op)
                        ber_pkg::OP_START:
                        begin
                            cmd.load_geom = 1'b1;
                            state_next    = ber_pkg::ST_START_MUL;
                        end
                        ber_pkg::OP_STEP:
                        begin
                            // drop the step when no ellipse is running
                            if (stat.active)
                            begin
                                cmd.step_mul = 1'b1;
                                state_next   = ber_pkg::ST_STEP_EVAL;
                            end
                        end
                        default:
                        begin
                            state_next = ber_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ber_pkg::ST_START_MUL:
            begin
                cmd.start_mul = 1'b1;
                state_next    = ber_pkg::ST_START_INIT;
            end
            ber_pkg::ST_START_INIT:
            begin
                cmd.start_init = 1'b1;
                state_next     = ber_pkg::ST_IDLE;
            end
            ber_pkg::ST_STEP_EVAL:
            begin
                cmd.step_eval = 1'b1;
                state_next    = ber_pkg::ST_STEP_COMMIT;
            end
            ber_pkg::ST_STEP_COMMIT:
            begin
                // hold until the output stage can take the new points
                if (stat.emit_free)
                begin
                    cmd.step_commit = 1'b1;
                    state_next      = ber_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ber_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_commit_waits, clk, rst_n, (state_reg == ber_pkg::ST_STEP_COMMIT && !stat.emit_free) |=> (state_reg == ber_pkg::ST_STEP_COMMIT), "commit left before output stage was free")

endmodule

// ===== hdl/ber_dp.sv =====
// Datapath of the ellipse rasterizer: geometry, position, error term and step decision.
// Depends on ber_pkg and assert_macros.svh; driven by ber_ctrl commands.
`include "assert_macros.svh"

module ber_dp #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ber_pkg::cmd_t           cmd,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [AXIS_BITS-1:0]    semi_x,
    input  logic [AXIS_BITS-1:0]    semi_y,
    output logic                    active,
    output logic [COORD_BITS+1:0]   pt_x_pos,
    output logic [COORD_BITS+1:0]   pt_x_neg,
    output logic [COORD_BITS+1:0]   pt_y_pos,
    output logic [COORD_BITS+1:0]   pt_y_neg,
    output logic                    pt_done
);

    localparam int X_W  = AXIS_BITS + 1;
    localparam int Y_W  = COORD_BITS;
    localparam int SQ_W = 2 * AXIS_BITS;
    localparam int PT_W = COORD_BITS + 2;
    localparam int E_W  = ber_pkg::ERR_BITS;
    localparam int N_W  = E_W + 2;
    localparam int T_W  = E_W + 3;
    localparam int OP_W = (Y_W > AXIS_BITS) ? Y_W : AXIS_BITS;

    logic [COORD_BITS-1:0]  cx_reg;
    logic [COORD_BITS-1:0]  cy_reg;
    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [AXIS_BITS-1:0]   semi_y_reg;
    logic [X_W-1:0]         pos_x_reg;
    logic [Y_W-1:0]         pos_y_reg;
    logic signed [E_W-1:0]  err_reg;
    logic                   active_reg;
    logic [E_W-1:0]         prod_a_reg;
    logic [E_W-1:0]         prod_b_reg;
    logic [E_W-1:0]         tri_x_reg;
    logic [E_W-1:0]         tri_y_reg;
    logic [E_W-1:0]         delta_reg;
    ber_pkg::move_t         move_reg;

    // multipliers
    logic [SQ_W-1:0]        sq_x_full;
    logic [SQ_W-1:0]        sq_y_full;
    logic [OP_W-1:0]        mul_a_op;
    logic [SQ_W+OP_W-1:0]   mul_a_full;
    logic [SQ_W+X_W-1:0]    mul_b_full;

    // start arithmetic
    logic signed [N_W-1:0]  n_twice;
    logic signed [N_W-1:0]  n_half;
    logic                   n_round;
    logic [E_W-1:0]         err_init;

    // step decision
    logic signed [T_W-1:0]  d_ext;
    logic signed [T_W-1:0]  p_ext;
    logic signed [T_W-1:0]  q_ext;
    logic signed [T_W-1:0]  aa_ext;
    logic signed [T_W-1:0]  bb_ext;
    logic signed [T_W-1:0]  t_h;
    logic signed [T_W-1:0]  t_v;
    logic                   t_h_le0;
    logic                   t_v_gt0;
    logic [E_W-1:0]         dq;
    logic [E_W-1:0]         dp;
    logic [E_W-1:0]         del_h;
    logic [E_W-1:0]         del_v;
    logic [E_W-1:0]         del_d;
    ber_pkg::move_t         move_sel;
    logic [E_W-1:0]         delta_sel;

    // commit
    logic                   x_inc;
    logic                   y_dec;
    logic                   done;

    assign sq_x_full  = semi_x * semi_x;
    assign sq_y_full  = semi_y * semi_y;
    assign mul_a_op   = cmd.step_mul ? OP_W'(pos_y_reg) : OP_W'(semi_y_reg);
    assign mul_a_full = sqx_reg * mul_a_op;
    assign mul_b_full = sqy_reg * pos_x_reg;

    // (a^2 + b^2) - 4 a^2 b, halved with rounding away from zero
    assign n_twice  = N_W'(sqx_reg) + N_W'(sqy_reg) - (N_W'(prod_a_reg) << 2);
    assign n_half   = n_twice >>> 1;
    assign n_round  = n_twice[0] & ~n_twice[N_W-1];
    assign err_init = E_W'(n_half) + E_W'(n_round);

    assign d_ext   = T_W'(err_reg);
    assign p_ext   = T_W'(prod_a_reg);
    assign q_ext   = T_W'(prod_b_reg);
    assign aa_ext  = T_W'(sqx_reg);
    assign bb_ext  = T_W'(sqy_reg);
    assign t_h     = ((d_ext + p_ext) <<< 1) - aa_ext;
    assign t_v     = ((d_ext - q_ext) <<< 1) - bb_ext;
    assign t_h_le0 = t_h[T_W-1] || (t_h == '0);
    assign t_v_gt0 = !t_v[T_W-1] && (t_v != '0);

    // error updates written with the old position: P = a^2 y, Q = b^2 x
    assign dq    = {prod_b_reg[E_W-2:0], 1'b0};
    assign dp    = {prod_a_reg[E_W-2:0], 1'b0};
    assign del_h = dq + tri_y_reg;
    assign del_v = tri_x_reg - dp;
    assign del_d = dq - dp + tri_x_reg + tri_y_reg;

    always_comb
    begin
        if (err_reg[E_W-1])
        begin
            move_sel = t_h_le0 ? ber_pkg::MOVE_H : ber_pkg::MOVE_D;
        end
        else if (err_reg != '0)
        begin
            move_sel = t_v_gt0 ? ber_pkg::MOVE_V : ber_pkg::MOVE_D;
        end
        else
        begin
            move_sel = ber_pkg::MOVE_D;
        end
        case (move_sel)
            ber_pkg::MOVE_H: delta_sel = del_h;
            ber_pkg::MOVE_V: delta_sel = del_v;
            default:         delta_sel = del_d;
        endcase
    end

    assign x_inc = (move_reg == ber_pkg::MOVE_H) || (move_reg == ber_pkg::MOVE_D);
    assign y_dec = (move_reg == ber_pkg::MOVE_V) || (move_reg == ber_pkg::MOVE_D);
    assign done  = y_dec && (pos_y_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (cmd.load_geom)
        begin
            active_reg <= 1'b0;
        end
        else if (cmd.start_init)
        begin
            active_reg <= 1'b1;
        end
        else if (cmd.step_commit && done)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_geom)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            sqx_reg    <= sq_x_full;
            sqy_reg    <= sq_y_full;
            semi_y_reg <= semi_y;
            pos_x_reg  <= '0;
            pos_y_reg  <= Y_W'(semi_y);
        end
        if (cmd.start_mul)
        begin
            prod_a_reg <= E_W'(mul_a_full);
            tri_x_reg  <= E_W'(sqx_reg) + E_W'({sqx_reg, 1'b0});
            tri_y_reg  <= E_W'(sqy_reg) + E_W'({sqy_reg, 1'b0});
        end
        if (cmd.start_init)
        begin
            err_reg <= err_init;
        end
        if (cmd.step_mul)
        begin
            prod_a_reg <= E_W'(mul_a_full);
            prod_b_reg <= E_W'(mul_b_full);
        end
        if (cmd.step_eval)
        begin
            move_reg  <= move_sel;
            delta_reg <= delta_sel;
        end
        if (cmd.step_commit)
        begin
            err_reg <= err_reg + $signed(delta_reg);
            if (x_inc)
            begin
                pos_x_reg <= pos_x_reg + X_W'(1);
            end
            if (done)
            begin
                pos_y_reg <= '0;
            end
            else if (y_dec)
            begin
                pos_y_reg <= pos_y_reg - Y_W'(1);
            end
        end
    end

    // points of the current position, taken by the output stage on commit
    assign pt_x_pos = PT_W'(cx_reg) + PT_W'(pos_x_reg);
    assign pt_x_neg = PT_W'(cx_reg) - PT_W'(pos_x_reg);
    assign pt_y_pos = PT_W'(cy_reg) + PT_W'(pos_y_reg);
    assign pt_y_neg = PT_W'(cy_reg) - PT_W'(pos_y_reg);
    assign pt_done  = done;
    assign active   = active_reg;

    `ASSERT_CLK(a_active_ends_on_commit, clk, rst_n, $fell(active_reg) |-> ($past(cmd.step_commit) || $past(cmd.load_geom)), "active cleared outside commit or restart")

endmodule

// ===== hdl/ber_out.sv =====
// Output stage of the ellipse rasterizer: holds one step's four points and emits them.
// Depends on ber_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ber_out #(
    parameter int COORD_BITS = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [COORD_BITS+1:0]                   pt_x_pos,
    input  logic [COORD_BITS+1:0]                   pt_x_neg,
    input  logic [COORD_BITS+1:0]                   pt_y_pos,
    input  logic [COORD_BITS+1:0]                   pt_y_neg,
    input  logic                                    pt_done,
    output logic                                    free,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]   m_axis_tdata,
    output logic                                    m_axis_tlast,
    output logic [0:0]                              m_axis_tuser
);

    localparam int PT_W   = COORD_BITS + 2;
    localparam int DATA_W = ((2 * PT_W + 7) / 8) * 8;

    logic            busy_reg;
    logic            busy_next;
    logic [1:0]      idx_reg;
    logic [1:0]      idx_next;
    logic [PT_W-1:0] xp_reg;
    logic [PT_W-1:0] xn_reg;
    logic [PT_W-1:0] yp_reg;
    logic [PT_W-1:0] yn_reg;
    logic            done_reg;
    logic            fire;
    logic            finish;
    logic [PT_W-1:0] x_sel;
    logic [PT_W-1:0] y_sel;

    assign fire   = busy_reg && m_axis_tready;
    assign finish = fire && (idx_reg == ber_pkg::LAST_POINT);
    assign free   = !busy_reg || finish;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xp_reg   <= pt_x_pos;
            xn_reg   <= pt_x_neg;
            yp_reg   <= pt_y_pos;
            yn_reg   <= pt_y_neg;
            done_reg <= pt_done;
        end
    end

    // order: (+x,+y), (+x,-y), (-x,+y), (-x,-y)
    assign x_sel = idx_reg[1] ? xn_reg : xp_reg;
    assign y_sel = idx_reg[0] ? yn_reg : yp_reg;

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = DATA_W'({y_sel, x_sel});
    assign m_axis_tlast  = (idx_reg == ber_pkg::LAST_POINT);
    assign m_axis_tuser  = done_reg;

    `ASSERT_NEVER(a_load_busy, clk, rst_n, load && !free, "points loaded over a run in progress")
    `ASSERT_CLK(a_done_steady, clk, rst_n, (fire && !m_axis_tlast) |=> (m_axis_tvalid && $stable(done_reg)), "run cut short or done flag changed")

endmodule

// ===== hdl/bresenham_ellipse_rasterizer_unit.sv =====
// Ellipse rasterizer, top level. A start item passes through the load, multiply and init
// states before the next item is taken; a step is multiplied, then evaluated, and its
// commit waits for a free output stage. Points leave one per cycle while tready is high.
// The output stage sets the sustained step rate; the error update overlaps the emission.
// Reset (rst_n low, asynchronous): sequencer idle, no ellipse active, output empty.
// Depends on ber_pkg, ber_ctrl, ber_dp and ber_out.
module bresenham_ellipse_rasterizer_unit #(
    parameter int AXIS_BITS  = 11,
    parameter int COORD_BITS = 12
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                s_axis_tvalid,
    output logic                                                s_axis_tready,
    // center_x, center_y, semi_x, semi_y (lowest bits first), zero padded
    input  logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // op: 0 = start, 1 = step
    input  logic [0:0]                                          s_axis_tuser,
    output logic                                                m_axis_tvalid,
    input  logic                                                m_axis_tready,
    // point_x, point_y (lowest bits first, two's complement), zero padded
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]               m_axis_tdata,
    output logic                                                m_axis_tlast,
    // ellipse_done
    output logic [0:0]                                          m_axis_tuser
);

    localparam int PT_W = COORD_BITS + 2;

    // unpacked input fields
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_BITS-1:0]  semi_x;
    logic [AXIS_BITS-1:0]  semi_y;

    ber_pkg::cmd_t    cmd;
    ber_pkg::status_t stat;
    logic             active;
    logic             emit_free;

    // snapshot of the four mirrored points for the output stage
    logic [PT_W-1:0]  pt_x_pos;
    logic [PT_W-1:0]  pt_x_neg;
    logic [PT_W-1:0]  pt_y_pos;
    logic [PT_W-1:0]  pt_y_neg;
    logic             pt_done;

    assign center_x = s_axis_tdata[COORD_BITS-1:0];
    assign center_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign semi_x   = s_axis_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
    assign semi_y   = s_axis_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];

    assign stat.active    = active;
    assign stat.emit_free = emit_free;

    // Sequencer: takes one item at a time, drops steps while no ellipse runs,
    // and holds the commit of a step until the previous points are all out.
    ber_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .op       (ber_pkg::op_t'(s_axis_tuser)),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: squares of the semi-axes and the initial error on start,
    // then per step the two products a^2*y and b^2*x, the move decision and
    // the error update.
    ber_dp #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .center_x (center_x),
        .center_y (center_y),
        .semi_x   (semi_x),
        .semi_y   (semi_y),
        .active   (active),
        .pt_x_pos (pt_x_pos),
        .pt_x_neg (pt_x_neg),
        .pt_y_pos (pt_y_pos),
        .pt_y_neg (pt_y_neg),
        .pt_done  (pt_done)
    );

    // Output stage: latch the points on commit and emit them one per cycle while tready
    // is high, marking the fourth with tlast.
    ber_out #(
        .COORD_BITS (COORD_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (cmd.step_commit),
        .pt_x_pos      (pt_x_pos),
        .pt_x_neg      (pt_x_neg),
        .pt_y_pos      (pt_y_pos),
        .pt_y_neg      (pt_y_neg),
        .pt_done       (pt_done),
        .free          (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/bresenham_ellipse_rasterizer_unit_tb.sv =====
// Self-checking testbench for bresenham_ellipse_rasterizer_unit: a directed table, then random
// ellipses, checked point by point against an in-bench model of the midpoint ellipse walk.
// Depends on ber_pkg and the RTL of the rasterizer; reads no files.
module bresenham_ellipse_rasterizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_BITS    = 11;
    localparam int COORD_BITS   = 12;
    localparam int PT_BITS      = COORD_BITS + 2;
    localparam int ERR_BITS     = ber_pkg::ERR_BITS;
    localparam int IN_BITS      = ((2*COORD_BITS + 2*AXIS_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = ((2*PT_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SHOWN_ERRORS = 10;

    // One emitted point, as the output channel carries it
    typedef struct packed {
        logic signed [PT_BITS-1:0] px;
        logic signed [PT_BITS-1:0] py;
        logic                      last;
        logic                      done;
    } ellipse_point_t;

    // How a directed row gets its expected points
    typedef enum logic [1:0] {
        CHK_PREDICT,    // from the walk model
        CHK_NONE,       // no point at all
        CHK_CENTER      // the center four times, done set; center typed in cx/cy
    } chk_t;

    typedef struct {
        ber_pkg::op_t          op;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [AXIS_BITS-1:0]  a;
        logic [AXIS_BITS-1:0]  b;
        chk_t                  how;
    } dir_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_BITS-1:0]   s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;

    // Walk model state: position, error term, squared axes, held center
    logic [AXIS_BITS:0]     trk_x      = '0;
    logic [COORD_BITS-1:0]  trk_y      = '0;
    logic signed [ERR_BITS-1:0] trk_err = '0;
    logic [2*AXIS_BITS-1:0] sq_a       = '0;
    logic [2*AXIS_BITS-1:0] sq_b       = '0;
    logic [COORD_BITS-1:0]  ctr_x      = '0;
    logic [COORD_BITS-1:0]  ctr_y      = '0;
    bit                     trk_active = 1'b0;

    // Points still owed by the block, oldest first
    ellipse_point_t pending_points [$];
    ellipse_point_t got_point;
    ellipse_point_t want_point;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int cycle_count        = 0;
    int counted_items      = 0;
    int traffic_phase      = 0;
    int starts_sent        = 0;
    int steps_sent         = 0;
    int points_checked     = 0;
    int ellipses_finished  = 0;

    // Directed table: idle steps, zero axes, field extremes, restart mid-ellipse, tiny circle
    dir_row_t dir_rows [24] = '{
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_NONE},
        '{ber_pkg::OP_START, 12'd100,  12'd200,  11'd0,    11'd0,    CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd100,  12'd200,  11'd0,    11'd0,    CHK_CENTER},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_NONE},
        '{ber_pkg::OP_START, 12'd4095, 12'd4095, 11'd0,    11'd0,    CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd4095, 12'd4095, 11'd0,    11'd0,    CHK_CENTER},
        '{ber_pkg::OP_START, 12'd0,    12'd0,    11'd2047, 11'd0,    CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_CENTER},
        '{ber_pkg::OP_START, 12'd0,    12'd0,    11'd3,    11'd2,    CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd4095, 12'd4095, 11'd2047, 11'd2047, CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd4095, 12'd4095, 11'd2047, 11'd2047, CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd4095, 12'd4095, 11'd2047, 11'd2047, CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd4095, 12'd4095, 11'd2047, 11'd2047, CHK_PREDICT},
        '{ber_pkg::OP_START, 12'd4095, 12'd0,    11'd2047, 11'd2047, CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_START, 12'd0,    12'd4095, 11'd0,    11'd2047, CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_START, 12'd2048, 12'd1365, 11'd1,    11'd1,    CHK_NONE},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_PREDICT},
        '{ber_pkg::OP_STEP,  12'd0,    12'd0,    11'd0,    11'd0,    CHK_NONE}
    };

    bresenham_ellipse_rasterizer_unit #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the walk model by one accepted item; return how many points it owes.
    // A start loads the geometry and the rounded initial error; a step while idle does nothing.
    function automatic int trace_ellipse_item(input ber_pkg::op_t op,
                                              input logic [COORD_BITS-1:0] cx_in,
                                              input logic [COORD_BITS-1:0] cy_in,
                                              input logic [AXIS_BITS-1:0] a_in,
                                              input logic [AXIS_BITS-1:0] b_in,
                                              output ellipse_point_t pts [4]);
        longint x, y, d, aa, bb, cx, cy, n, t, la, lb;
        bit     fin;
        if (op == ber_pkg::OP_START)
        begin
            la    = a_in;
            lb    = b_in;
            ctr_x = cx_in;
            ctr_y = cy_in;
            sq_a  = (2*AXIS_BITS)'(la * la);
            sq_b  = (2*AXIS_BITS)'(lb * lb);
            trk_x = '0;
            trk_y = COORD_BITS'(lb);
            // twice the initial error, then halve rounding half away from zero
            n = la*la + lb*lb - 4*la*la*lb;
            d = (n >= 0) ? (n + 1) / 2 : -((1 - n) / 2);
            trk_err    = ERR_BITS'(d);
            trk_active = 1'b1;
            return 0;
        end
        if (!trk_active)
            return 0;

        x  = trk_x;
        y  = trk_y;
        d  = trk_err;
        aa = sq_a;
        bb = sq_b;
        cx = ctr_x;
        cy = ctr_y;

        // Mirror the current position into the four quadrants before moving
        pts[0] = '{PT_BITS'(cx + x), PT_BITS'(cy + y), 1'b0, 1'b0};
        pts[1] = '{PT_BITS'(cx + x), PT_BITS'(cy - y), 1'b0, 1'b0};
        pts[2] = '{PT_BITS'(cx - x), PT_BITS'(cy + y), 1'b0, 1'b0};
        pts[3] = '{PT_BITS'(cx - x), PT_BITS'(cy - y), 1'b1, 1'b0};

        if (d < 0)
        begin
            t = 2 * (d + aa * y) - aa;
            x++;
            if (t <= 0)
                d += bb * (2 * x + 1);
            else
            begin
                y--;
                d += 2 * (bb * x - aa * y) + aa + bb;
            end
        end
        else if (d > 0)
        begin
            t = 2 * (d - bb * x) - bb;
            y--;
            if (t > 0)
                d += aa * (1 - 2 * y);
            else
            begin
                x++;
                d += 2 * (bb * x - aa * y) + aa + bb;
            end
        end
        else
        begin
            x++;
            y--;
            d += 2 * (bb * x - aa * y) + aa + bb;
        end

        fin     = (y < 0);
        trk_x   = (AXIS_BITS+1)'(x);
        trk_y   = fin ? '0 : COORD_BITS'(y);
        trk_err = ERR_BITS'(d);
        if (fin)
            trk_active = 1'b0;
        for (int k = 0; k < 4; k++)
            pts[k].done = fin;
        return 4;
    endfunction

    // Offer one item, hold it until taken, then book the points it owes.
    // Called in the time step of the previous acceptance, so valid gets one assignment here.
    task automatic offer_item(input ber_pkg::op_t op,
                              input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy,
                              input logic [AXIS_BITS-1:0] a,
                              input logic [AXIS_BITS-1:0] b,
                              input chk_t how);
        ellipse_point_t pts [4];
        int             n;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'({b, a, cy, cx});
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        if (op == ber_pkg::OP_START)
            starts_sent++;
        else
            steps_sent++;
        n = trace_ellipse_item(op, cx, cy, a, b, pts);
        case (how)
            CHK_PREDICT:
                for (int k = 0; k < n; k++)
                    pending_points.push_back(pts[k]);
            CHK_CENTER:
                for (int k = 0; k < 4; k++)
                    pending_points.push_back('{PT_BITS'(cx), PT_BITS'(cy), k == 3, 1'b1});
            default:
                ;
        endcase
    endtask

    // Drop valid and hold off until every owed point has come back
    task automatic drain_points();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Pick the traffic pattern from how far the random part has got;
    // drain at each change so the sender pauses with nothing in flight
    task automatic pace_traffic();
        int want_phase;
        want_phase = (counted_items * 4) / RANDOM_ITEMS;
        if (want_phase > 3)
            want_phase = 3;
        if (want_phase != traffic_phase)
        begin
            drain_points();
            traffic_phase = want_phase;
            case (traffic_phase)
                1:       begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
        end
    endtask

    // Send a step with random ignored fields; count it only if an ellipse is in progress
    task automatic random_step();
        if (trk_active)
            counted_items++;
        offer_item(ber_pkg::OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   AXIS_BITS'($urandom), AXIS_BITS'($urandom), CHK_PREDICT);
    endtask

    // Random ellipses: mostly small ones walked to the end, some medium,
    // a few with full-range axes cut short by a restart, and stray idle steps
    task automatic random_ellipses();
        int                    pick;
        int                    step_cap;
        int                    taken;
        logic [AXIS_BITS-1:0]  a;
        logic [AXIS_BITS-1:0]  b;
        while (counted_items < RANDOM_ITEMS)
        begin
            pace_traffic();
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                a = AXIS_BITS'($urandom_range(12));
                b = AXIS_BITS'($urandom_range(12));
                step_cap = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 1 << 20;
            end
            else if (pick < 95)
            begin
                a = AXIS_BITS'($urandom_range(60));
                b = AXIS_BITS'($urandom_range(60));
                step_cap = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 1 << 20;
            end
            else
            begin
                a = AXIS_BITS'($urandom);
                b = AXIS_BITS'($urandom);
                step_cap = $urandom_range(1, 6);
            end

            counted_items++;
            offer_item(ber_pkg::OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom), a, b,
                       CHK_PREDICT);
            taken = 0;
            while (trk_active && taken < step_cap && counted_items < RANDOM_ITEMS)
            begin
                pace_traffic();
                random_step();
                taken++;
            end
            // Poke an idle block now and then; these steps must give nothing
            if (!trk_active && $urandom_range(99) < 30)
                repeat ($urandom_range(1, 2))
                    random_step();
        end
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Check every taken point against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_point.px   = m_axis_tdata[PT_BITS-1:0];
            got_point.py   = m_axis_tdata[2*PT_BITS-1:PT_BITS];
            got_point.last = m_axis_tlast;
            got_point.done = m_axis_tuser[0];
            points_checked++;
            if (got_point.last && got_point.done)
                ellipses_finished++;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected point: x=%0d y=%0d last=%0b done=%0b",
                             got_point.px, got_point.py, got_point.last, got_point.done);
            end
            else
            begin
                want_point = pending_points.pop_front();
                if (got_point.px !== want_point.px || got_point.py !== want_point.py ||
                    got_point.last !== want_point.last || got_point.done !== want_point.done)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display({"point mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                                  " got x=%0d y=%0d last=%0b done=%0b"},
                                 want_point.px, want_point.py, want_point.last,
                                 want_point.done, got_point.px, got_point.py,
                                 got_point.last, got_point.done);
                end
            end
        end
    end

    // Watchdog: end a hung run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bresenham_ellipse_rasterizer_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        // Hold reset at the start, then release it once for the whole run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side
        foreach (dir_rows[i])
            offer_item(dir_rows[i].op, dir_rows[i].cx, dir_rows[i].cy,
                       dir_rows[i].a, dir_rows[i].b, dir_rows[i].how);

        random_ellipses();

        // Drain the last points, then give the pipeline time to show any stray one
        drain_points();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_points.size() != 0)
        begin
            mismatches++;
            $display("%0d expected points never arrived", pending_points.size());
        end
        $display("covered %0d starts and %0d steps; %0d points checked, %0d ellipses completed",
                 starts_sent, steps_sent, points_checked, ellipses_finished);
        $display("idle and stall phases run; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("bresenham_ellipse_rasterizer_unit regression: pass");
        else
            $display("bresenham_ellipse_rasterizer_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ber_pkg.sv
hdl/ber_ctrl.sv
hdl/ber_dp.sv
hdl/ber_out.sv
hdl/bresenham_ellipse_rasterizer_unit.sv
tb/sv/bresenham_ellipse_rasterizer_unit_tb.sv
